>>> rtl/bti_pkg.sv
package bti_pkg;

  localparam int unsigned XNodesDefault = 16;
  localparam int unsigned YNodesDefault = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned NumW = 130;
  localparam int unsigned DenW = 66;

  typedef enum logic [1:0] {
    KIND_WR_X    = 2'd0,
    KIND_WR_Y    = 2'd1,
    KIND_WR_GRID = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IdxW-1:0]   index_x;
    logic [IdxW-1:0]   index_y;
    logic signed [31:0] data;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               degenerate_cell;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLAMP_X,
    ST_CLAMP_Y,
    ST_SRCH_X,
    ST_SRCH_Y,
    ST_NODE_X1,
    ST_NODE_X2,
    ST_NODE_Y1,
    ST_NODE_Y2,
    ST_DIFF,
    ST_G11,
    ST_G12,
    ST_G21,
    ST_G22,
    ST_MA,
    ST_MB,
    ST_MDEN,
    ST_DIV,
    ST_SAT,
    ST_OUT
  } state_e;

  // Command to the shared multiply-accumulate unit.
  typedef struct packed {
    logic                start;
    logic signed [65:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic                clear;
  } mac_cmd_t;

endpackage

>>> rtl/bti_mac.sv
// Shared 66x33 signed multiply-accumulate, one 34x33 partial product per cycle, low half of a then high half.
module bti_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bti_pkg::mac_cmd_t     cmd_i,
  output logic                  busy_o,
  output logic signed [129:0]   acc_o
);
  logic [1:0]          phase_q, phase_d;
  logic signed [65:0]  a_q, a_d;
  logic signed [32:0]  b_q, b_d;
  logic signed [129:0] acc_q, acc_d;
  logic signed [33:0]  a_part;
  logic signed [66:0]  prod;

  // low half of a is unsigned, high half signed
  assign a_part = phase_q[1] ? {a_q[65], a_q[65:33]} : {1'b0, a_q[32:0]};
  assign prod = a_part * b_q;

  always_comb begin
    phase_d = phase_q;
    a_d = a_q;
    b_d = b_q;
    acc_d = acc_q;
    if (cmd_i.start) begin
      phase_d = 2'd1;
      a_d = cmd_i.mul_a;
      b_d = cmd_i.mul_b;
      if (cmd_i.clear) acc_d = '0;
    end else if (phase_q == 2'd1) begin
      phase_d = 2'd2;
      acc_d = acc_q + {{63{prod[66]}}, prod};
    end else if (phase_q == 2'd2) begin
      phase_d = 2'd0;
      acc_d = acc_q + {{30{prod[66]}}, prod, 33'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    acc_q <= acc_d;
  end

  assign busy_o = (phase_q != 2'd0);
  assign acc_o = acc_q;
endmodule

>>> rtl/bti_div.sv
// Restoring divider, one quotient bit per cycle; the quotient has the numerator's width.
module bti_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bti_pkg::NumW-1:0]      num_i,
  input  logic [bti_pkg::DenW-1:0]      den_i,
  output logic                          done_o,
  output logic [bti_pkg::NumW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(bti_pkg::NumW + 1);
  localparam int unsigned RemW = bti_pkg::DenW + 1;

  logic                      busy_q, busy_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [bti_pkg::NumW-1:0]  n_q, n_d;
  logic [RemW-1:0]           r_q, r_d;
  logic [bti_pkg::DenW-1:0]  den_q, den_d;
  logic                      done_q, done_d;
  logic [RemW-1:0]           r_sh;
  logic [RemW-1:0]           r_sub;

  assign r_sh = {r_q[RemW-2:0], n_q[bti_pkg::NumW-1]};
  assign r_sub = r_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    n_d = n_q;
    r_d = r_q;
    den_d = den_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CntW'(bti_pkg::NumW);
      n_d = num_i;
      r_d = '0;
      den_d = den_i;
    end else if (busy_q) begin
      // quotient bits shift into n from the bottom
      if (r_sh >= {1'b0, den_q}) begin
        r_d = r_sub;
        n_d = {n_q[bti_pkg::NumW-2:0], 1'b1};
      end else begin
        r_d = r_sh;
        n_d = {n_q[bti_pkg::NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = n_q;
endmodule

>>> rtl/bilinear_table_interpolator.sv
// Bilinear lookup table, signed Q16.16.
// Input channel in_valid_i / in_stall_o carries an in_item_t. kind selects a
// write of an x node, a y node or a grid value (index_x column, index_y row),
// or a query at (query_x, query_y). Writes with an index at or beyond the node
// count are dropped. Writes give no result and can be taken every cycle while idle.
// A query gives one out_item_t on out_valid_o / out_stall_i: the value
// interpolated in the clamped cell, truncated toward zero and saturated, or
// zero with degenerate_cell set when the cell has zero width or height.
// A query goes through clamping to the node range, a binary search per axis
// (skipped when the first or last cell is taken), node and grid reads, seven
// passes through the shared multiply-accumulate unit, the one-bit-per-cycle
// divider of the 130-bit numerator, and saturation. A zero-area cell skips
// the grid reads and the arithmetic. After reset the block sweeps the grid
// memory to zero, one entry per cycle, with in_stall_o high; node tables
// clear at once. The input stays stalled while an item is in work or a
// result waits; a stalled result holds its value until taken, and the next
// item is taken the cycle after.
module bilinear_table_interpolator #(
  parameter int unsigned X_NODES = bti_pkg::XNodesDefault,
  parameter int unsigned Y_NODES = bti_pkg::YNodesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bti_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bti_pkg::out_item_t   out_item_o
);
  localparam int unsigned XW = (X_NODES > 1) ? $clog2(X_NODES) : 1;
  localparam int unsigned YW = (Y_NODES > 1) ? $clog2(Y_NODES) : 1;
  localparam int unsigned GD = X_NODES * Y_NODES;
  localparam int unsigned GW = $clog2(GD);
  localparam int unsigned XCW = XW + 2;
  localparam int unsigned YCW = YW + 2;

  logic signed [31:0] xn_q [X_NODES];
  logic signed [31:0] yn_q [Y_NODES];
  logic signed [31:0] grid_mem [GD];
  logic signed [31:0] grid_rd_q;

  bti_pkg::state_e st_q, st_d;
  logic          clr_q;
  logic [GW:0]   clr_cnt_q;

  logic signed [31:0] qx_q, qx_d, qy_q, qy_d;
  logic signed [XCW-1:0] lo_x_q, lo_x_d, hi_x_q, hi_x_d;
  logic signed [YCW-1:0] lo_y_q, lo_y_d, hi_y_q, hi_y_d;
  logic [XW-1:0] cx_q, cx_d;
  logic [YW-1:0] cy_q, cy_d;
  logic signed [31:0] x1_q, x1_d, x2_q, x2_d, y1_q, y1_d, y2_q, y2_d;
  logic signed [32:0] dx2_q, dx2_d, dx1_q, dx1_d, dy2_q, dy2_d, dy1_q, dy1_d;
  logic signed [32:0] dxc_q, dxc_d, dyc_q, dyc_d;
  logic signed [31:0] g11_q, g11_d, g12_q, g12_d, g21_q, g21_d, g22_q, g22_d;
  logic signed [65:0] ra_q, ra_d;
  logic signed [129:0] num_q, num_d;
  logic [1:0]    step_q, step_d;
  logic          mwait_q, mwait_d;
  logic          neg_q, neg_d;
  logic          dstart;
  logic [bti_pkg::NumW-1:0] dnum;
  logic [bti_pkg::DenW-1:0] dden;
  logic          ddone;
  logic [bti_pkg::NumW-1:0] dquot;
  bti_pkg::out_item_t res_q, res_d;
  logic          ov_q, ov_d;

  bti_pkg::mac_cmd_t mcmd;
  logic          mbusy;
  logic signed [129:0] macc;

  logic [GW-1:0] g_raddr;
  logic          in_acc;
  logic [YW-1:0] wr_cy;

  // shared reads of node tables by sequencer index
  logic [XW-1:0] xrd_idx;
  logic [YW-1:0] yrd_idx;
  logic signed [31:0] xrd, yrd;
  logic [XCW-1:0] mid_x;
  logic [YCW-1:0] mid_y;

  bti_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mcmd),
    .busy_o (mbusy),
    .acc_o  (macc)
  );

  bti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (dnum),
    .den_i   (dden),
    .done_o  (ddone),
    .quot_o  (dquot)
  );

  assign in_stall_o = clr_q || (st_q != bti_pkg::ST_IDLE) || ov_q;
  assign in_acc = in_valid_i && !in_stall_o;

  // node and grid writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < X_NODES; i++) xn_q[i] <= '0;
      for (int i = 0; i < Y_NODES; i++) yn_q[i] <= '0;
    end else if (in_acc) begin
      if (in_item_i.kind == bti_pkg::KIND_WR_X && 32'(in_item_i.index_x) < X_NODES)
        xn_q[XW'(in_item_i.index_x)] <= in_item_i.data;
      if (in_item_i.kind == bti_pkg::KIND_WR_Y && 32'(in_item_i.index_y) < Y_NODES)
        yn_q[YW'(in_item_i.index_y)] <= in_item_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == (GW+1)'(GD - 1)) clr_q <= 1'b0;
    end
  end

  assign wr_cy = YW'(in_item_i.index_y);

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      grid_mem[clr_cnt_q[GW-1:0]] <= '0;
    end else if (in_acc && in_item_i.kind == bti_pkg::KIND_WR_GRID
                 && 32'(in_item_i.index_x) < X_NODES
                 && 32'(in_item_i.index_y) < Y_NODES) begin
      grid_mem[GW'(32'(wr_cy) * X_NODES + 32'(in_item_i.index_x))] <= in_item_i.data;
    end
    grid_rd_q <= grid_mem[g_raddr];
  end

  assign mid_x = XCW'(($signed(lo_x_q) + $signed(hi_x_q)) >>> 1);
  assign mid_y = YCW'(($signed(lo_y_q) + $signed(hi_y_q)) >>> 1);

  always_comb begin
    xrd_idx = cx_q;
    yrd_idx = cy_q;
    case (st_q)
      bti_pkg::ST_SRCH_X: xrd_idx = mid_x[XW-1:0];
      bti_pkg::ST_SRCH_Y: yrd_idx = mid_y[YW-1:0];
      bti_pkg::ST_NODE_X2: xrd_idx = cx_q + 1'b1;
      bti_pkg::ST_NODE_Y2: yrd_idx = cy_q + 1'b1;
      default: ;
    endcase
  end
  assign xrd = xn_q[xrd_idx];
  assign yrd = yn_q[yrd_idx];

  always_comb begin
    g_raddr = GW'(32'(cy_q) * X_NODES + 32'(cx_q));
    case (st_q)
      bti_pkg::ST_G11: g_raddr = GW'(32'(cy_q) * X_NODES + 32'(cx_q) + 1);
      bti_pkg::ST_G12: g_raddr = GW'((32'(cy_q) + 1) * X_NODES + 32'(cx_q));
      bti_pkg::ST_G21: g_raddr = GW'((32'(cy_q) + 1) * X_NODES + 32'(cx_q) + 1);
      default: ;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      bti_pkg::ST_IDLE:
        if (in_acc && in_item_i.kind == bti_pkg::KIND_QUERY) st_d = bti_pkg::ST_CLAMP_X;
      bti_pkg::ST_CLAMP_X: st_d = bti_pkg::ST_CLAMP_Y;
      bti_pkg::ST_CLAMP_Y: st_d = bti_pkg::ST_SRCH_X;
      bti_pkg::ST_SRCH_X:
        if ($signed(lo_x_q) > $signed(hi_x_q)) st_d = bti_pkg::ST_SRCH_Y;
      bti_pkg::ST_SRCH_Y:
        if ($signed(lo_y_q) > $signed(hi_y_q)) st_d = bti_pkg::ST_NODE_X1;
      bti_pkg::ST_NODE_X1: st_d = bti_pkg::ST_NODE_X2;
      bti_pkg::ST_NODE_X2: st_d = bti_pkg::ST_NODE_Y1;
      bti_pkg::ST_NODE_Y1: st_d = bti_pkg::ST_NODE_Y2;
      bti_pkg::ST_NODE_Y2: st_d = bti_pkg::ST_DIFF;
      bti_pkg::ST_DIFF:
        if (x2_q == x1_q || y2_q == y1_q) st_d = bti_pkg::ST_OUT;
        else st_d = bti_pkg::ST_G11;
      bti_pkg::ST_G11: st_d = bti_pkg::ST_G12;
      bti_pkg::ST_G12: st_d = bti_pkg::ST_G21;
      bti_pkg::ST_G21: st_d = bti_pkg::ST_G22;
      bti_pkg::ST_G22: st_d = bti_pkg::ST_MA;
      bti_pkg::ST_MA: if (step_q == 2'd3 && mwait_q && !mbusy) st_d = bti_pkg::ST_MB;
      bti_pkg::ST_MB: if (step_q == 2'd1 && mwait_q && !mbusy) st_d = bti_pkg::ST_MDEN;
      bti_pkg::ST_MDEN: if (mwait_q && !mbusy) st_d = bti_pkg::ST_DIV;
      bti_pkg::ST_DIV: if (ddone) st_d = bti_pkg::ST_SAT;
      bti_pkg::ST_SAT: st_d = bti_pkg::ST_OUT;
      bti_pkg::ST_OUT: st_d = bti_pkg::ST_IDLE;
      default: st_d = bti_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic signed [129:0] nabs;
    logic signed [65:0]  dabs;
    qx_d = qx_q; qy_d = qy_q;
    lo_x_d = lo_x_q; hi_x_d = hi_x_q; lo_y_d = lo_y_q; hi_y_d = hi_y_q;
    cx_d = cx_q; cy_d = cy_q;
    x1_d = x1_q; x2_d = x2_q; y1_d = y1_q; y2_d = y2_q;
    dx2_d = dx2_q; dx1_d = dx1_q; dy2_d = dy2_q; dy1_d = dy1_q;
    dxc_d = dxc_q; dyc_d = dyc_q;
    g11_d = g11_q; g12_d = g12_q; g21_d = g21_q; g22_d = g22_q;
    ra_d = ra_q; num_d = num_q; step_d = step_q; mwait_d = mwait_q; neg_d = neg_q;
    res_d = res_q; ov_d = ov_q;
    mcmd = '0;
    dstart = 1'b0;
    nabs = num_q[129] ? -num_q : num_q;
    dabs = macc[65] ? -macc[65:0] : macc[65:0];
    dnum = nabs;
    dden = dabs;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      bti_pkg::ST_IDLE: begin
        qx_d = in_item_i.query_x;
        qy_d = in_item_i.query_y;
      end
      bti_pkg::ST_CLAMP_X: begin
        if (qx_q < xn_q[0]) qx_d = xn_q[0];
        else if (qx_q > xn_q[X_NODES-1]) qx_d = xn_q[X_NODES-1];
      end
      bti_pkg::ST_CLAMP_Y: begin
        if (qy_q < yn_q[0]) qy_d = yn_q[0];
        else if (qy_q > yn_q[Y_NODES-1]) qy_d = yn_q[Y_NODES-1];
        // set up the x search with first and last cell shortcuts
        if (qx_q < xn_q[1]) begin
          lo_x_d = XCW'(1); hi_x_d = '0;
        end else if (qx_q >= xn_q[X_NODES-2]) begin
          lo_x_d = XCW'(X_NODES - 1); hi_x_d = XCW'(X_NODES - 2);
        end else begin
          lo_x_d = '0; hi_x_d = XCW'(X_NODES - 2);
        end
      end
      bti_pkg::ST_SRCH_X: begin
        if ($signed(lo_x_q) <= $signed(hi_x_q)) begin
          if (qx_q < xrd) hi_x_d = mid_x - 1'b1;
          else lo_x_d = mid_x + 1'b1;
        end else begin
          if ($signed(hi_x_q) < 0) cx_d = '0;
          else cx_d = hi_x_q[XW-1:0];
          if (qy_q < yn_q[1]) begin
            lo_y_d = YCW'(1); hi_y_d = '0;
          end else if (qy_q >= yn_q[Y_NODES-2]) begin
            lo_y_d = YCW'(Y_NODES - 1); hi_y_d = YCW'(Y_NODES - 2);
          end else begin
            lo_y_d = '0; hi_y_d = YCW'(Y_NODES - 2);
          end
        end
      end
      bti_pkg::ST_SRCH_Y: begin
        if ($signed(lo_y_q) <= $signed(hi_y_q)) begin
          if (qy_q < yrd) hi_y_d = mid_y - 1'b1;
          else lo_y_d = mid_y + 1'b1;
        end else begin
          if ($signed(hi_y_q) < 0) cy_d = '0;
          else cy_d = hi_y_q[YW-1:0];
        end
      end
      bti_pkg::ST_NODE_X1: x1_d = xrd;
      bti_pkg::ST_NODE_X2: x2_d = xrd;
      bti_pkg::ST_NODE_Y1: y1_d = yrd;
      bti_pkg::ST_NODE_Y2: y2_d = yrd;
      bti_pkg::ST_DIFF: begin
        dxc_d = 33'(x2_q) - 33'(x1_q);
        dyc_d = 33'(y2_q) - 33'(y1_q);
        dx2_d = 33'(x2_q) - 33'(qx_q);
        dx1_d = 33'(qx_q) - 33'(x1_q);
        dy2_d = 33'(y2_q) - 33'(qy_q);
        dy1_d = 33'(qy_q) - 33'(y1_q);
        if (x2_q == x1_q || y2_q == y1_q) begin
          res_d.interp_value = '0;
          res_d.degenerate_cell = 1'b1;
        end
        step_d = '0;
        mwait_d = 1'b0;
      end
      // grid data is registered and arrives in the state after its address
      bti_pkg::ST_G11: g11_d = grid_rd_q;
      bti_pkg::ST_G12: g12_d = grid_rd_q;
      bti_pkg::ST_G21: g21_d = grid_rd_q;
      bti_pkg::ST_G22: g22_d = grid_rd_q;
      bti_pkg::ST_MA: begin
        // a = g11*dx2 + g12*dx1, then b = g21*dx2 + g22*dx1
        if (!mwait_q) begin
          mcmd.start = 1'b1;
          mcmd.clear = !step_q[0];
          mcmd.mul_b = step_q[0] ? dx1_q : dx2_q;
          case (step_q)
            2'd0: mcmd.mul_a = 66'(g11_q);
            2'd1: mcmd.mul_a = 66'(g12_q);
            2'd2: mcmd.mul_a = 66'(g21_q);
            default: mcmd.mul_a = 66'(g22_q);
          endcase
          mwait_d = 1'b1;
        end else if (!mbusy) begin
          mwait_d = 1'b0;
          step_d = step_q + 1'b1;
          if (step_q == 2'd1) ra_d = macc[65:0];
          if (step_q == 2'd3) num_d = macc;
        end
      end
      bti_pkg::ST_MB: begin
        // num = a*dy2 + b*dy1
        if (!mwait_q) begin
          mcmd.start = 1'b1;
          mcmd.clear = !step_q[0];
          mcmd.mul_a = step_q[0] ? num_q[65:0] : ra_q;
          mcmd.mul_b = step_q[0] ? dy1_q : dy2_q;
          mwait_d = 1'b1;
        end else if (!mbusy) begin
          mwait_d = 1'b0;
          step_d = step_q + 1'b1;
          if (step_q == 2'd1) num_d = macc;
        end
      end
      bti_pkg::ST_MDEN: begin
        if (!mwait_q) begin
          mcmd.start = 1'b1;
          mcmd.clear = 1'b1;
          mcmd.mul_a = 66'(dxc_q);
          mcmd.mul_b = dyc_q;
          mwait_d = 1'b1;
        end else if (!mbusy) begin
          mwait_d = 1'b0;
          dstart = 1'b1;
          neg_d = num_q[129] ^ macc[65];
        end
      end
      bti_pkg::ST_DIV: ;
      bti_pkg::ST_SAT: begin
        res_d.degenerate_cell = 1'b0;
        if (neg_q) begin
          if (dquot > 130'h80000000) res_d.interp_value = 32'sh80000000;
          else res_d.interp_value = 32'(-dquot);
        end else begin
          if (dquot > 130'h7fffffff) res_d.interp_value = 32'sh7fffffff;
          else res_d.interp_value = dquot[31:0];
        end
      end
      bti_pkg::ST_OUT: ov_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bti_pkg::ST_IDLE;
      ov_q <= 1'b0;
      step_q <= '0;
      mwait_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      step_q <= step_d;
      mwait_q <= mwait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d; qy_q <= qy_d;
    lo_x_q <= lo_x_d; hi_x_q <= hi_x_d; lo_y_q <= lo_y_d; hi_y_q <= hi_y_d;
    cx_q <= cx_d; cy_q <= cy_d;
    x1_q <= x1_d; x2_q <= x2_d; y1_q <= y1_d; y2_q <= y2_d;
    dx2_q <= dx2_d; dx1_q <= dx1_d; dy2_q <= dy2_d; dy1_q <= dy1_d;
    dxc_q <= dxc_d; dyc_q <= dyc_d;
    g11_q <= g11_d; g12_q <= g12_d; g21_q <= g21_d; g22_q <= g22_d;
    ra_q <= ra_d; num_q <= num_d; neg_q <= neg_d; res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_item_o = res_q;
endmodule

>>> rtl/bti_checker.sv
module bti_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  bti_pkg::out_item_t out_item_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.degenerate_cell |-> out_item_o.interp_value == 32'sd0)
    else $error("degenerate cell with nonzero value");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result right after accept");
endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
